// ----- rtl/position_delta_run_encoder_core_defines.svh -----
// Assertion macros for the checker file of the position delta run encoder.
`ifndef POSITION_DELTA_RUN_ENCODER_CORE_DEFINES_SVH
`define POSITION_DELTA_RUN_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define PDRE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("position delta run encoder check failed");

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define PDRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("position delta run encoder check failed");

`endif

// ----- rtl/pdre_pkg.sv -----
// Types and constants shared by the position delta run encoder files.
package pdre_pkg;

	localparam int POSITION_BITS = 13;
	localparam int GROUP_LIMIT   = 255;
	localparam int MAX_RESULTS   = 34;
	localparam int SEQ_BITS      = 16;
	localparam int DELTA_BITS    = 8;
	localparam int COUNT_BITS    = 8;
	localparam int BUDGET_BITS   = $clog2(MAX_RESULTS);

	typedef logic [POSITION_BITS-1:0] pos_t;
	typedef logic [DELTA_BITS-1:0]    delta_t;
	typedef logic [COUNT_BITS-1:0]    count_t;
	typedef logic [SEQ_BITS-1:0]      seq_t;
	typedef logic [BUDGET_BITS-1:0]   budget_t;

	// Record kinds.
	localparam logic RECORD_GROUP = 1'b0;
	localparam logic RECORD_SEQ   = 1'b1;

	localparam pos_t   LIMIT_POS   = pos_t'(GROUP_LIMIT);
	localparam delta_t LIMIT_DELTA = delta_t'(GROUP_LIMIT);
	localparam count_t LIMIT_COUNT = count_t'(GROUP_LIMIT);

	// One group to be written out: distance from the base and its hit count.
	typedef struct packed {
		logic   valid;
		pos_t   gap;
		count_t hits;
	} seg_t;

	// Work handed from the hit tracker to the record sequencer for one hit.
	typedef struct packed {
		seg_t first;
		seg_t second;
		logic err;
		seq_t sid;
	} plan_t;

	// One output record.
	typedef struct packed {
		logic   kind;
		delta_t delta;
		count_t run_count;
		seq_t   seq;
		logic   err;
		logic   last;
	} record_t;

endpackage

// ----- rtl/pdre_if.sv -----
// Valid/ready stream interfaces for hit beats and record beats.
interface pdre_hit_if import pdre_pkg::*; ();
	logic valid;
	logic ready;
	pos_t position;
	seq_t sequence_id;
	logic list_end;

	modport source (output valid, output position, output sequence_id, output list_end,
		input ready);
	modport sink (input valid, input position, input sequence_id, input list_end,
		output ready);
endinterface

interface pdre_rec_if import pdre_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   record_kind;
	delta_t delta;
	count_t run_count;
	seq_t   seq_out;
	logic   order_error;
	logic   run_last;

	modport source (output valid, output record_kind, output delta, output run_count,
		output seq_out, output order_error, output run_last, input ready);
	modport sink (input valid, input record_kind, input delta, input run_count,
		input seq_out, input order_error, input run_last, output ready);
endinterface

// ----- rtl/position_delta_run_encoder_core.sv -----
// Position delta run encoder: turns sorted hit positions into group, escape and id records.
//
// Each accepted hit beat yields its group records (at most two: a closed or split group and,
// on the last hit of a list, the final flush), escape records ahead of any group whose
// distance exceeds 255, and always one id record last, flagged run_last. An item passes
// through an accept step, then its group records G (0 to 2), its escape steps E, that is
// (distance-1)/255 for each group, and last the id record. The escape steps come from a
// single shared compare and subtract unit that takes one limit off the distance per cycle
// while the output slot is free; escapes past the 34-record budget are stepped through
// without being shown. The input is not ready while an item is in flight; an output
// register lets the next item enter while the id record of the previous one waits.
// There is no clearing pass after reset.
module position_delta_run_encoder_core import pdre_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	pdre_hit_if.sink    hit,
	pdre_rec_if.source  rec
);

	logic    take;
	logic    idle;
	plan_t   plan;
	record_t out_rec;

	assign take = hit.valid && hit.ready;
	assign hit.ready = idle;

	pdre_hit_tracker u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.position    (hit.position),
		.sequence_id (hit.sequence_id),
		.list_end    (hit.list_end),
		.plan        (plan)
	);

	pdre_record_sequencer u_sequencer (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.plan      (plan),
		.out_ready (rec.ready),
		.idle      (idle),
		.out_valid (rec.valid),
		.out_rec   (out_rec)
	);

	// Record beat payload.
	assign rec.record_kind = out_rec.kind;
	assign rec.delta = out_rec.delta;
	assign rec.run_count = out_rec.run_count;
	assign rec.seq_out = out_rec.seq;
	assign rec.order_error = out_rec.err;
	assign rec.run_last = out_rec.last;

endmodule

// ----- rtl/pdre_hit_tracker.sv -----
// Tracks the open group of a list and plans the groups that each hit closes.
module pdre_hit_tracker import pdre_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  take,
	input  pos_t  position,
	input  seq_t  sequence_id,
	input  logic  list_end,
	output plan_t plan
);

	pos_t   cur_q;
	pos_t   base_q;
	count_t cnt_q;
	logic   started_q;

	pos_t                c0;
	pos_t                b0;
	count_t              n0;
	pos_t                pe;
	pos_t                dist0;
	pos_t                dist1;
	logic                err;
	logic [COUNT_BITS:0] n_inc;
	pos_t                c1;
	pos_t                b1;
	count_t              n1;
	seg_t                seg_a;
	seg_t                seg_b;

	// Work out the groups this hit closes and the state it leaves behind.
	always_comb begin
		c0 = started_q ? cur_q : position;
		b0 = started_q ? base_q : '0;
		n0 = started_q ? cnt_q : '0;
		err = started_q && (position < cur_q);
		pe = err ? cur_q : position;
		dist0 = (c0 >= b0) ? c0 - b0 : '0;
		n_inc = {1'b0, n0} + (COUNT_BITS + 1)'(1);
		seg_a = '0;
		c1 = c0;
		b1 = b0;
		n1 = n_inc[COUNT_BITS-1:0];
		if (pe == c0 && dist0 <= LIMIT_POS) begin
			// Same position: a run that reaches the limit is split off.
			if (n_inc > (COUNT_BITS + 1)'(GROUP_LIMIT)) begin
				seg_a = '{valid: 1'b1, gap: dist0, hits: LIMIT_COUNT};
				b1 = c0;
				n1 = count_t'(1);
			end
		end else begin
			// New position, or a gap too wide to hold the run: close the group.
			seg_a = '{valid: 1'b1, gap: dist0, hits: n0};
			b1 = c0;
			c1 = pe;
			n1 = count_t'(1);
		end
		dist1 = (c1 >= b1) ? c1 - b1 : '0;
		seg_b = '{valid: list_end, gap: dist1, hits: n1};
		plan.err = err;
		plan.sid = sequence_id;
		if (seg_a.valid) begin
			plan.first = seg_a;
			plan.second = seg_b;
		end else begin
			plan.first = seg_b;
			plan.second = '0;
		end
	end

	// State update; the last hit of a list returns to the reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			base_q <= '0;
			cnt_q <= '0;
			started_q <= 1'b0;
		end else if (take) begin
			if (list_end) begin
				cur_q <= '0;
				base_q <= '0;
				cnt_q <= '0;
				started_q <= 1'b0;
			end else begin
				cur_q <= c1;
				base_q <= b1;
				cnt_q <= n1;
				started_q <= 1'b1;
			end
		end
	end

endmodule

// ----- rtl/pdre_escape_alu.sv -----
// Shared step unit: tests a group distance against the limit and takes one limit off.
module pdre_escape_alu import pdre_pkg::*; (
	input  pos_t gap,
	output logic over,
	output pos_t reduced
);

	assign over = gap > LIMIT_POS;
	assign reduced = gap - LIMIT_POS;

endmodule

// ----- rtl/pdre_record_sequencer.sv -----
// Steps the planned groups, escapes and id record, one per cycle unless stalled.
module pdre_record_sequencer import pdre_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    take,
	input  plan_t   plan,
	input  logic    out_ready,
	output logic    idle,
	output logic    out_valid,
	output record_t out_rec
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SEG  = 2'd1;
	localparam logic [1:0] ST_ID   = 2'd2;

	logic [1:0] state_q;
	seg_t       work_q;
	seg_t       next_q;
	logic       err_q;
	seq_t       sid_q;
	budget_t    budget_q;
	logic       out_valid_q;
	record_t    out_q;

	logic    over;
	pos_t    reduced;
	logic    slot_free;
	logic    emit;
	record_t emit_rec;
	budget_t nseg;

	pdre_escape_alu u_alu (
		.gap     (work_q.gap),
		.over    (over),
		.reduced (reduced)
	);

	assign slot_free = !out_valid_q || out_ready;
	assign nseg = budget_t'(plan.first.valid) + budget_t'(plan.second.valid);
	assign idle = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_rec = out_q;

	// Record produced in this cycle, if any.
	always_comb begin
		emit = 1'b0;
		emit_rec = '0;
		emit_rec.err = err_q;
		unique case (state_q)
			ST_SEG: begin
				if (slot_free) begin
					emit_rec.kind = RECORD_GROUP;
					if (over) begin
						// Escapes beyond the budget still advance, unseen.
						emit = (budget_q != '0);
						emit_rec.delta = LIMIT_DELTA;
					end else begin
						emit = 1'b1;
						emit_rec.delta = work_q.gap[DELTA_BITS-1:0];
						emit_rec.run_count = work_q.hits;
					end
				end
			end
			ST_ID: begin
				emit = slot_free;
				emit_rec.kind = RECORD_SEQ;
				emit_rec.seq = sid_q;
				emit_rec.last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= plan.first.valid ? ST_SEG : ST_ID;
					end
				end
				ST_SEG: begin
					if (slot_free && !over && !next_q.valid) begin
						state_q <= ST_ID;
					end
				end
				ST_ID: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Work registers for the item in flight.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && take) begin
			work_q <= plan.first;
			next_q <= plan.second;
			err_q <= plan.err;
			sid_q <= plan.sid;
			budget_q <= budget_t'(MAX_RESULTS - 1) - nseg;
		end else if (state_q == ST_SEG && slot_free) begin
			if (over) begin
				work_q.gap <= reduced;
				if (budget_q != '0) begin
					budget_q <= budget_q - budget_t'(1);
				end
			end else if (next_q.valid) begin
				work_q <= next_q;
				next_q.valid <= 1'b0;
			end
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_rec;
		end
	end

endmodule

// ----- rtl/pdre_checker.sv -----
// Port-level checks for the position delta run encoder, bound to the top level.
`include "position_delta_run_encoder_core_defines.svh"

module pdre_checker import pdre_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   hit_valid,
	input logic   hit_ready,
	input logic   rec_valid,
	input logic   rec_ready,
	input logic   rec_kind,
	input delta_t rec_delta,
	input count_t rec_count,
	input seq_t   rec_seq,
	input logic   rec_err,
	input logic   rec_last
);

	logic [$bits(record_t)-1:0] rec_payload;

	// Whole record beat contents, gathered for the hold check.
	assign rec_payload = {rec_kind, rec_delta, rec_count, rec_seq, rec_err, rec_last};

	// A stalled record beat holds its contents.
	`PDRE_ASSERT_NEXT(a_rec_hold, clk, arst_n, rec_valid && !rec_ready, rec_valid && $stable(rec_payload))

	// After a hit is taken the input is not ready in the following cycle.
	`PDRE_ASSERT_NEXT(a_busy_after_take, clk, arst_n, hit_valid && hit_ready, !hit_ready)

	// Only the id record closes an item, and every id record does.
	`PDRE_ASSERT_IMPL(a_last_is_id, clk, arst_n, rec_valid, rec_kind == rec_last)

	// Group records carry no sequence id.
	`PDRE_ASSERT_IMPL(a_group_no_seq, clk, arst_n, rec_valid && !rec_kind, rec_seq == '0)

	// Id records carry no delta and no count.
	`PDRE_ASSERT_IMPL(a_id_no_group, clk, arst_n, rec_valid && rec_kind, rec_delta == '0 && rec_count == '0)

endmodule

bind position_delta_run_encoder_core pdre_checker u_pdre_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.hit_valid (hit.valid),
	.hit_ready (hit.ready),
	.rec_valid (rec.valid),
	.rec_ready (rec.ready),
	.rec_kind  (rec.record_kind),
	.rec_delta (rec.delta),
	.rec_count (rec.run_count),
	.rec_seq   (rec.seq_out),
	.rec_err   (rec.order_error),
	.rec_last  (rec.run_last)
);
